>>> hw/rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Concurrent assertion forms used by the itoa_checker module of this project.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/itoa_pkg.sv
// ============================================================================
// itoa_pkg
// Types, constants and helper functions shared by the radix conversion block.
// ============================================================================
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 8;
   localparam int ADDR_W      = $clog2(VALUE_WIDTH);
   localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
   localparam int BIT_W       = $clog2(VALUE_WIDTH);
   localparam int REQ_FIELD_W = VALUE_WIDTH + RADIX_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

   localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 8'h57;  // 'a' - 10
   localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic store_digit;
      logic sign_load;
      logic mem_read;
      logic char_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
      logic more_digits;
      logic minus;
      logic out_free;
      logic cnt_one;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] base;
      base = (d >= RADIX_DEC) ? CHAR_ALPHA_BASE : CHAR_ZERO;
      return base + CHAR_W'(d);
   endfunction

endpackage

>>> hw/rtl/itoa_ctrl.sv
// ============================================================================
// itoa_ctrl
// Sequencer for the conversion: divide loop, digit storage and emission.
// ============================================================================
`timescale 1ns / 1ps

module itoa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  itoa_pkg::dp_status_type sts,
   output itoa_pkg::ctrl_cmd_type  cmd
);
   import itoa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (sts.div_last) state_in = ST_STORE;
         end
         ST_STORE: begin
            priority if (sts.more_digits) state_in = ST_DIVIDE;
            else if (sts.minus)           state_in = ST_SIGN;
            else                          state_in = ST_READ;
         end
         ST_SIGN: begin
            if (sts.out_free) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) state_in = sts.cnt_one ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_STORE: begin
            cmd.store_digit = 1'b1;
         end
         ST_SIGN: begin
            cmd.sign_load = sts.out_free;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
         end
         ST_EMIT: begin
            cmd.char_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hw/rtl/itoa_dp.sv
// ============================================================================
// itoa_dp
// Datapath: operand setup, bit-serial divider, digit memory and output stage.
// ============================================================================
`timescale 1ns / 1ps

module itoa_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [itoa_pkg::VALUE_WIDTH-1:0]     value,
   input  logic [itoa_pkg::RADIX_W-1:0]         radix,
   input  logic                                 unsigned_mode,
   input  itoa_pkg::ctrl_cmd_type               cmd,
   output itoa_pkg::dp_status_type              sts,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [itoa_pkg::CHAR_W-1:0]          rsp_char,
   output logic                                 rsp_last
);
   import itoa_pkg::*;

   logic [VALUE_WIDTH-1:0] work_ff, work_in;
   logic [RADIX_W-1:0]     rem_ff, rem_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   minus_ff, minus_in;
   logic [BIT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [RADIX_W-1:0]     rd_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [RADIX_W-1:0]     digit_mem [VALUE_WIDTH];

   logic [RADIX_W-1:0]     radix_clamp;
   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag;
   logic [RADIX_W:0]       trial;
   logic [RADIX_W:0]       diff;
   logic                   ge;
   logic [CNT_W-1:0]       count_dec;
   logic                   out_free;

   // Operand setup.
   always_comb begin
      priority if (radix < RADIX_MIN) radix_clamp = RADIX_MIN;
      else if (radix > RADIX_MAX)     radix_clamp = RADIX_MAX;
      else                            radix_clamp = radix;
      neg = !unsigned_mode && value[VALUE_WIDTH-1];
      mag = neg ? (~value + VALUE_WIDTH'(1)) : value;
   end

   // One restoring division step: shift in the next dividend bit.
   assign trial = {rem_ff, work_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, radix_ff};
   assign ge    = trial >= {1'b0, radix_ff};

   assign count_dec = count_ff - CNT_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      work_in    = work_ff;
      rem_in     = rem_ff;
      radix_in   = radix_ff;
      minus_in   = minus_ff;
      bit_cnt_in = bit_cnt_ff;
      count_in   = count_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.load) begin
         work_in    = mag;
         rem_in     = '0;
         radix_in   = radix_clamp;
         minus_in   = neg && (radix_clamp == RADIX_DEC);
         bit_cnt_in = '0;
         count_in   = '0;
      end
      if (cmd.div_step) begin
         work_in    = {work_ff[VALUE_WIDTH-2:0], ge};
         rem_in     = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
         bit_cnt_in = bit_cnt_ff + BIT_W'(1);
      end
      if (cmd.store_digit) begin
         rem_in   = '0;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.sign_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CHAR_MINUS;
         rsp_last_in  = 1'b0;
      end
      if (cmd.char_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = digit_char(rd_ff);
         rsp_last_in  = (count_ff == CNT_W'(1));
         count_in     = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bit_cnt_ff   <= bit_cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      minus_ff    <= minus_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digit memory: least significant digit at address zero.
   always_ff @(posedge clock) begin
      if (cmd.store_digit) begin
         digit_mem[count_ff[ADDR_W-1:0]] <= rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_ff <= digit_mem[count_dec[ADDR_W-1:0]];
      end
   end

   always_comb begin
      sts.div_last    = (bit_cnt_ff == BIT_W'(VALUE_WIDTH - 1));
      sts.more_digits = (work_ff != '0) && (count_ff != CNT_W'(VALUE_WIDTH - 1));
      sts.minus       = minus_ff;
      sts.out_free    = out_free;
      sts.cnt_one     = (count_ff == CNT_W'(1));
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> hw/rtl/integer_to_ascii_radix_top.sv
// ============================================================================
// integer_to_ascii_radix_top
// Converts a 32-bit integer to ASCII digits in radix 2..36, most significant first.
// ============================================================================
// With a minus sign, the first character to leave is the sign.
// The block takes a new transaction only when idle, once the last character has
// entered the output register; the shared divider forms one quotient bit per cycle.
// For each character the sequencer reads the digit memory and then emits it,
// waiting while the result side is not ready.
// Reset is synchronous and active high; it idles the sequencer and empties the
// output register. The digit memory is not cleared.
`timescale 1ns / 1ps

module integer_to_ascii_radix_top (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata fields, lowest bit up: value [31:0], radix [37:32], zero pad.
   input  logic [itoa_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser fields: unsigned_mode [0].
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata fields, lowest bit up: char_code [7:0].
   output logic [itoa_pkg::CHAR_W-1:0]        rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);
   import itoa_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // The sequencer takes a transaction only when idle. The divider then runs
   // VALUE_WIDTH steps per digit and stores each remainder; the digits are
   // read back from the top of the memory and pass through a one-entry output
   // register, so a new transaction can be taken while the last character waits.
   itoa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   itoa_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .value         (req_tdata[VALUE_WIDTH-1:0]),
      .radix         (req_tdata[VALUE_WIDTH +: RADIX_W]),
      .unsigned_mode (req_tuser),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_char      (rsp_tdata),
      .rsp_last      (rsp_tlast)
   );

endmodule

>>> hw/rtl/itoa_checker.sv
// ============================================================================
// itoa_checker
// Port-level checks on the conversion block, bound to its top level.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itoa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [itoa_pkg::CHAR_W-1:0]      rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);
   import itoa_pkg::*;

   `ASSERT_ALWAYS(a_reset_empties_output, clock, reset |=> !rsp_tvalid, "output valid after reset")
   `ASSERT_RST(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "input ready right after a transaction")
   `ASSERT_RST(a_no_output_after_accept, clock, reset, (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid, "result appeared right after a transaction")
   `ASSERT_RST(a_valid_holds, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "result valid dropped while stalled")
   `ASSERT_RST(a_data_holds, clock, reset, (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tlast)), "result changed while stalled")

endmodule

bind integer_to_ascii_radix_top itoa_checker u_itoa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

>>> verif/itoa_radix_checker.sv
// ============================================================================
// itoa_radix_checker
// Watches both streams of the radix conversion block, predicts the ASCII
// characters of every accepted number and compares them with the output.
// ============================================================================
`timescale 1ns / 1ps

module itoa_radix_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [itoa_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [itoa_pkg::CHAR_W-1:0]        rsp_tdata,
   input  logic                               rsp_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output int                                 mismatch_count,
   output int                                 chars_pending
);
   import itoa_pkg::*;

   localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
   localparam int                REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              is_last;
   } ascii_char_type;

   ascii_char_type expected_chars[$];
   int             reported;

   initial begin
      mismatch_count = 0;
      chars_pending  = 0;
      reported       = 0;
   end

   // Works out the characters of one number and appends them to the queue.
   function automatic void queue_number_chars(input logic [VALUE_WIDTH-1:0] value,
                                              input logic [RADIX_W-1:0]     radix_in,
                                              input logic                   unsigned_mode);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [RADIX_W-1:0]     base;
      logic [RADIX_W-1:0]     digits [VALUE_WIDTH];
      logic                   negative;
      ascii_char_type         item;
      int                     count;
      base = radix_in;
      if (base < RADIX_MIN) begin
         base = RADIX_MIN;
      end
      if (base > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      magnitude = value;
      negative  = 1'b0;
      if (!unsigned_mode && value[VALUE_WIDTH-1]) begin
         magnitude = ~value + VALUE_WIDTH'(1);
         negative  = (base == RADIX_DEC);
      end
      count = 0;
      do begin
         digits[count] = RADIX_W'(magnitude % VALUE_WIDTH'(base));
         magnitude     = magnitude / VALUE_WIDTH'(base);
         count++;
      end while (magnitude != 0 && count < VALUE_WIDTH);
      if (negative) begin
         item.code    = CHAR_MINUS;
         item.is_last = 1'b0;
         expected_chars.push_back(item);
      end
      for (int i = count - 1; i >= 0; i--) begin
         if (digits[i] < RADIX_DEC) begin
            item.code = CHAR_ZERO + CHAR_W'(digits[i]);
         end else begin
            item.code = LOWER_A + CHAR_W'(digits[i] - RADIX_DEC);
         end
         item.is_last = (i == 0);
         expected_chars.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            queue_number_chars(req_tdata[VALUE_WIDTH-1:0],
                               req_tdata[VALUE_WIDTH +: RADIX_W], req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               if (reported < REPORT_LIMIT) begin
                  $display("%0t: unexpected character %h last %b", $time,
                           rsp_tdata, rsp_tlast);
               end
               reported++;
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (want.code !== rsp_tdata || want.is_last !== rsp_tlast) begin
                  if (reported < REPORT_LIMIT) begin
                     $display("%0t: character mismatch, expected %h last %b, got %h last %b",
                              $time, want.code, want.is_last, rsp_tdata, rsp_tlast);
                  end
                  reported++;
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         chars_pending <= expected_chars.size();
      end
   end

endmodule

>>> verif/tb_integer_to_ascii_radix_top.sv
// ============================================================================
// tb_integer_to_ascii_radix_top
// Drives numbers into the radix conversion block under varying stream flow
// and lets the checker compare every emitted character with its prediction.
// ============================================================================
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix_top;
   import itoa_pkg::*;

   // Each number costs the block one divide per digit, plus up to 32 output
   // characters that may each sit through receiver stalls, plus sender gaps.
   // Roughly 410 numbers go in; the limit covers the slowest correct run
   // several times over.
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int ITEMS_PER_PHASE = 97;
   // The long receiver hold starts once this many transactions have gone in,
   // which falls early in the first random phase, where the sender never rests.
   localparam int PRESSURE_AT     = 40;
   localparam int HOLD_CYCLES     = 4000;
   localparam int DRAIN_CYCLES    = 200;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [CHAR_W-1:0]      rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   // Flow control knobs, in percent of cycles.
   int   send_idle_pct  = 0;
   int   stall_pct      = 0;
   logic rsp_hold       = 1'b0;
   int   items_accepted = 0;
   int   cycle_count    = 0;

   int   mismatch_count;
   int   chars_pending;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   integer_to_ascii_radix_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   itoa_radix_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   // The receiver drops ready at random at the current stall rate, and keeps it
   // low throughout the long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   // The long hold runs in its own process and counts its own cycles. The
   // sender keeps offering numbers meanwhile, so the output backs up into the
   // sequencer and req_tready stays low until the hold lifts.
   initial begin
      wait (items_accepted >= PRESSURE_AT);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog: a run that hangs is a failed run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Offers one number and returns once the transaction has been accepted.
   // It is always entered right after a rising edge. Idle gaps come first,
   // so valid never drops and rises again within one time step.
   task automatic send_number(input logic [VALUE_WIDTH-1:0] value,
                              input logic [RADIX_W-1:0]     radix,
                              input logic                   unsigned_mode);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= REQ_TDATA_W'({radix, value});
      req_tuser  <= unsigned_mode;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_accepted++;
   endtask

   initial begin
      logic [VALUE_WIDTH-1:0] value;
      logic [RADIX_W-1:0]     radix;
      int                     width;
      int                     pick;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed numbers: zero, the extremes of both readings of the value,
      // the most negative signed value, signs in decimal versus other bases,
      // unsigned decimal with the top bit set, and clamping of the radix
      // from both sides, including radix codes 0, 1, 37 and 63.
      send_number(32'h0000_0000, 6'd10, 1'b0);
      send_number(32'h0000_0000, 6'd2,  1'b1);
      send_number(32'h7FFF_FFFF, 6'd10, 1'b0);
      send_number(32'h8000_0000, 6'd10, 1'b0);
      send_number(32'h8000_0000, 6'd16, 1'b0);
      send_number(32'h8000_0000, 6'd2,  1'b1);
      send_number(32'hFFFF_FFFF, 6'd10, 1'b1);
      send_number(32'hFFFF_FFFF, 6'd2,  1'b1);
      send_number(32'hFFFF_FFFF, 6'd10, 1'b0);
      send_number(32'hFFFF_FFFF, 6'd36, 1'b0);
      send_number(32'hFFFF_FFFF, 6'd36, 1'b1);
      send_number(32'h0000_0005, 6'd0,  1'b0);
      send_number(32'h0000_0007, 6'd1,  1'b1);
      send_number(32'h0000_0023, 6'd37, 1'b0);
      send_number(32'hDEAD_BEEF, 6'd63, 1'b1);
      send_number(32'h0000_0023, 6'd36, 1'b0);
      send_number(32'h0000_0009, 6'd10, 1'b0);
      send_number(32'h00AB_CDEF, 6'd16, 1'b1);
      send_number(32'hFFFF_FFF8, 6'd8,  1'b0);
      send_number(-32'sd123456789, 6'd10, 1'b0);
      send_number(-32'sd123456789, 6'd10, 1'b1);
      send_number(32'h0000_0001, 6'd2,  1'b0);

      // Random numbers in four flow phases: free flow, a resting sender,
      // a stalling receiver, and light idling on both sides.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct    <= 0;
            end
            1: begin
               send_idle_pct = 46;
               stall_pct    <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct    <= 46;
            end
            default: begin
               send_idle_pct = 10;
               stall_pct    <= 10;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Magnitudes of every bit length, so short and long digit
            // strings both appear; about a quarter are negated.
            width = $urandom_range(1, VALUE_WIDTH);
            value = $urandom >> (VALUE_WIDTH - width);
            if ($urandom_range(3) == 0) begin
               value = ~value + VALUE_WIDTH'(1);
            end
            pick = $urandom_range(99);
            if (pick < 25) begin
               radix = RADIX_DEC;
            end else if (pick < 75) begin
               radix = RADIX_W'($urandom_range(2, 36));
            end else begin
               radix = RADIX_W'($urandom_range(0, 63));
            end
            send_number(value, radix, 1'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // Let the checker take in the last transaction, then wait for every
      // predicted character and a quiet stretch after that.
      @(posedge clock);
      while (chars_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ctrl.sv
hw/rtl/itoa_dp.sv
hw/rtl/integer_to_ascii_radix_top.sv
hw/rtl/itoa_checker.sv
verif/itoa_radix_checker.sv
verif/tb_integer_to_ascii_radix_top.sv
